### rtl/core/egcd_pkg.sv
// Shared types and constants for the extended GCD unit.
package egcd_pkg;

    localparam int STEP_W = 6;

    typedef logic [STEP_W-1:0] step_t;

    // Step counter saturates at its all-ones value
    localparam step_t STEP_MAX = '1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_LAUNCH,
        ST_DIV,
        ST_FIN
    } state_t;

    // Sequencer to divide/accumulate unit
    typedef struct packed {
        logic start;
    } div_ctl_t;

    // Divide/accumulate unit back to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

### rtl/core/egcd_in_if.sv
// Request channel carrying the two signed operands.
interface egcd_in_if #(
    parameter int OPERAND_WIDTH = 32
);
    logic                            valid;
    logic                            ready;
    logic signed [OPERAND_WIDTH-1:0] operand_a;
    logic signed [OPERAND_WIDTH-1:0] operand_b;

    modport source (output valid, output operand_a, output operand_b, input ready);
    modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

### rtl/core/egcd_out_if.sv
// Result channel carrying the divisor, Bezout coefficients and step count.
interface egcd_out_if #(
    parameter int OPERAND_WIDTH = 32
);
    logic                            valid;
    logic                            ready;
    logic        [OPERAND_WIDTH-1:0] divisor;
    logic signed [OPERAND_WIDTH-1:0] coef_x;
    logic signed [OPERAND_WIDTH-1:0] coef_y;
    egcd_pkg::step_t                 step_count;

    modport source (output valid, output divisor, output coef_x, output coef_y,
                    output step_count, input ready);
    modport sink   (input valid, input divisor, input coef_x, input coef_y,
                    input step_count, output ready);
endinterface

### rtl/core/egcd_divacc.sv
// Bit-serial restoring divider with quotient-times-coefficient accumulation.
module egcd_divacc #(
    parameter int W = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  egcd_pkg::div_ctl_t ctl,
    output egcd_pkg::div_sts_t sts,
    input  logic [W-1:0]      dividend,
    input  logic [W-1:0]      divisor,
    input  logic [W-1:0]      mult_x,
    input  logic [W-1:0]      mult_y,
    output logic [W-1:0]      remainder,
    output logic [W-1:0]      acc_x,
    output logic [W-1:0]      acc_y
);
    import egcd_pkg::*;

    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     dvd_reg, dvd_next;
    logic [W-1:0]     accx_reg, accx_next;
    logic [W-1:0]     accy_reg, accy_next;

    logic [W:0]       trial;
    logic [W:0]       diff;
    logic             qbit;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb
    begin
        trial = {rem_reg, dvd_reg[W-1]};
        diff  = trial - {1'b0, divisor};
        qbit  = ~diff[W];
    end

    // Control: run for one quotient bit per cycle, pulse done at the end
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Datapath: remainder, dividend shift and Horner accumulation of q*mult
    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        accx_next = accx_reg;
        accy_next = accy_reg;
        if (ctl.start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            accx_next = '0;
            accy_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = qbit ? diff[W-1:0] : trial[W-1:0];
            dvd_next  = {dvd_reg[W-2:0], 1'b0};
            accx_next = {accx_reg[W-2:0], 1'b0} + (qbit ? mult_x : '0);
            accy_next = {accy_reg[W-2:0], 1'b0} + (qbit ? mult_y : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        accx_reg <= accx_next;
        accy_reg <= accy_next;
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign remainder = rem_reg;
    assign acc_x     = accx_reg;
    assign acc_y     = accy_reg;

    // Done only once the shifting has stopped
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    // A finished remainder is below the divisor
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && divisor != '0) |-> (rem_reg < divisor))
        else $error("remainder not below divisor");

    // Start always launches a run
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |=> busy_reg)
        else $error("start did not launch the divider");

endmodule

### rtl/core/extended_gcd_unit.sv
// Extended Euclidean GCD with Bezout coefficients: sequencer and top level.
//
//   channel    | dir | fields                                  | handshake
//   -----------+-----+-----------------------------------------+------------
//   operands   | in  | operand_a, operand_b                    | valid/ready
//   results    | out | divisor, coef_x, coef_y, step_count     | valid/ready
//
// One request at a time. A request passes ST_PREP, then ST_LAUNCH and ST_DIV
// once per division, then ST_FIN; with a zero operand ST_PREP goes straight
// to ST_FIN. The shared divider produces one quotient bit per cycle.
// Reset clears the sequencer and the result valid; no memories.
// A finished result waits in the output register, and the next request is
// accepted while it waits; a stalled output holds the sequencer in ST_FIN.
module extended_gcd_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    egcd_in_if.sink     operands,
    egcd_out_if.source  results
);
    import egcd_pkg::*;

    localparam int W = OPERAND_WIDTH;

    state_t   state_reg, state_next;

    logic [W-1:0] va_reg, vb_reg;
    logic [W-1:0] big_reg, small_reg;
    logic [W-1:0] px_reg, py_reg, qx_reg, qy_reg;
    logic         swapped_reg;
    step_t        steps_reg;

    logic         out_valid_reg;
    logic [W-1:0] out_div_reg, out_cx_reg, out_cy_reg;
    step_t        out_steps_reg;

    logic [W-1:0] mag_a, mag_b, big_c, small_c;
    logic         swap_c;
    logic [W-1:0] cx_sel, cy_sel;

    div_ctl_t     div_ctl;
    div_sts_t     div_sts;
    logic [W-1:0] div_rem, div_accx, div_accy;

    logic         out_free;
    logic         load_out;
    logic         take_in;

    // Shared divide/accumulate unit
    egcd_divacc #(.W(W)) u_divacc (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .sts       (div_sts),
        .dividend  (big_reg),
        .divisor   (small_reg),
        .mult_x    (qx_reg),
        .mult_y    (qy_reg),
        .remainder (div_rem),
        .acc_x     (div_accx),
        .acc_y     (div_accy)
    );

    // Magnitudes and ordering of the operands
    always_comb
    begin
        mag_a   = va_reg[W-1] ? ('0 - va_reg) : va_reg;
        mag_b   = vb_reg[W-1] ? ('0 - vb_reg) : vb_reg;
        swap_c  = mag_a < mag_b;
        big_c   = swap_c ? mag_b : mag_a;
        small_c = swap_c ? mag_a : mag_b;
    end

    // Undo the swap; the operand signs are applied when the result is loaded
    always_comb
    begin
        cx_sel = swapped_reg ? qy_reg : qx_reg;
        cy_sel = swapped_reg ? qx_reg : qy_reg;
    end

    assign out_free = !out_valid_reg || results.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (operands.valid)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                state_next = (small_c == '0) ? ST_FIN : ST_LAUNCH;
            end
            ST_LAUNCH:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_sts.done)
                    state_next = (div_rem == '0) ? ST_FIN : ST_LAUNCH;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        operands.ready = 1'b0;
        div_ctl.start  = 1'b0;
        load_out       = 1'b0;
        unique case (state_reg)
            ST_IDLE:   operands.ready = 1'b1;
            ST_LAUNCH: div_ctl.start  = 1'b1;
            ST_FIN:    load_out       = out_free;
            default:   ;
        endcase
    end

    assign take_in = operands.valid && operands.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers: capture, set up, and advance one Euclid step
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            va_reg <= operands.operand_a;
            vb_reg <= operands.operand_b;
        end

        if (state_reg == ST_PREP)
        begin
            big_reg     <= big_c;
            swapped_reg <= swap_c;
            steps_reg   <= '0;
            px_reg      <= W'(1);
            py_reg      <= '0;
            if (small_c == '0)
            begin
                // One or both operands zero: result is the larger magnitude
                small_reg <= big_c;
                qx_reg    <= (big_c != '0) ? W'(1) : '0;
                qy_reg    <= '0;
            end
            else
            begin
                small_reg <= small_c;
                qx_reg    <= '0;
                qy_reg    <= W'(1);
            end
        end
        else if (state_reg == ST_DIV && div_sts.done && div_rem != '0)
        begin
            px_reg    <= qx_reg;
            py_reg    <= qy_reg;
            qx_reg    <= px_reg - div_accx;
            qy_reg    <= py_reg - div_accy;
            big_reg   <= small_reg;
            small_reg <= div_rem;
            if (steps_reg != STEP_MAX)
                steps_reg <= steps_reg + 1'b1;
        end

        if (load_out)
        begin
            out_div_reg   <= small_reg;
            out_cx_reg    <= va_reg[W-1] ? ('0 - cx_sel) : cx_sel;
            out_cy_reg    <= vb_reg[W-1] ? ('0 - cy_sel) : cy_sel;
            out_steps_reg <= steps_reg;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.divisor    = out_div_reg;
    assign results.coef_x     = out_cx_reg;
    assign results.coef_y     = out_cy_reg;
    assign results.step_count = out_steps_reg;

    // Never divide by zero
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LAUNCH || state_reg == ST_DIV) |-> (small_reg != '0))
        else $error("division launched with zero divisor");

    // The divider is quiet whenever a request may be accepted
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_sts.busy)
        else $error("divider busy while sequencer idle");

    // A new result appears only from the finishing state
    a_load_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result loaded outside the finishing state");

endmodule

### dv/tb.sv
// Testbench for the extended GCD unit: directed, random and back-pressure requests.
`timescale 1ns / 100ps

module tb;

    import egcd_pkg::*;

    localparam int W           = 32;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int IDLE_MAX    = 18;

    typedef struct {
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [W-1:0] divisor;
        logic [W-1:0] coef_x;
        logic [W-1:0] coef_y;
        step_t        step_count;
    } bezout_t;

    logic clk;
    logic rst_n;

    bezout_t bezout_q[$];
    int      errors;
    bit      in_idle;
    bit      out_idle;
    int      hold_len;

    egcd_in_if  #(.OPERAND_WIDTH(W)) op_if ();
    egcd_out_if #(.OPERAND_WIDTH(W)) res_if ();

    extended_gcd_unit #(.OPERAND_WIDTH(W)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (op_if),
        .results  (res_if)
    );

    // Free-running clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Extended Euclid on magnitudes, then undo the swap and the signs
    function automatic bezout_t solve_bezout(input logic [W-1:0] a, input logic [W-1:0] b);
        bezout_t      res;
        logic [W-1:0] big;
        logic [W-1:0] sml;
        logic [W-1:0] rem;
        logic [W-1:0] quo;
        logic [W-1:0] px, py, qx, qy, nx, ny, tmp;
        bit           swapped;
        step_t        steps;
        big     = a[W-1] ? -a : a;
        sml     = b[W-1] ? -b : b;
        swapped = 1'b0;
        steps   = '0;
        if (big < sml)
        begin
            tmp     = big;
            big     = sml;
            sml     = tmp;
            swapped = 1'b1;
        end
        res.a = a;
        res.b = b;
        if (big == '0)
        begin
            res.divisor = '0;
            qx          = '0;
            qy          = '0;
        end
        else if (sml == '0)
        begin
            res.divisor = big;
            qx          = 1;
            qy          = '0;
        end
        else
        begin
            px          = 1;
            py          = '0;
            qx          = '0;
            qy          = 1;
            res.divisor = sml;
            rem         = big % sml;
            while (rem != '0)
            begin
                quo         = big / sml;
                nx          = px - quo * qx;
                ny          = py - quo * qy;
                px          = qx;
                py          = qy;
                qx          = nx;
                qy          = ny;
                big         = sml;
                sml         = rem;
                res.divisor = rem;
                if (steps != STEP_MAX)
                    steps = steps + 1'b1;
                rem = big % sml;
            end
        end
        if (swapped)
        begin
            tmp = qx;
            qx  = qy;
            qy  = tmp;
        end
        res.coef_x     = a[W-1] ? -qx : qx;
        res.coef_y     = b[W-1] ? -qy : qy;
        res.step_count = steps;
        return res;
    endfunction

    // Negate half of the time
    function automatic logic [W-1:0] random_sign(input logic [W-1:0] v);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // Consecutive Fibonacci numbers give the longest remainder chains
    task automatic fib_pair(input int n, output logic [W-1:0] fa, output logic [W-1:0] fb);
        logic [W-1:0] t;
        fa = 1;
        fb = 1;
        for (int i = 2; i < n; i++)
        begin
            t  = fa + fb;
            fb = fa;
            fa = t;
        end
    endtask

    // Drive one request at the falling edge and hold it until accepted
    task automatic send_pair(input logic [W-1:0] a, input logic [W-1:0] b);
        int gap;
        gap = in_idle ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0)
        begin
            op_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        op_if.valid     = 1'b1;
        op_if.operand_a = a;
        op_if.operand_b = b;
        do
            @(posedge clk);
        while (!op_if.ready);
        bezout_q.push_back(solve_bezout(a, b));
        @(negedge clk);
    endtask

    task automatic wait_drain();
        op_if.valid = 1'b0;
        while (bezout_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string field, input bezout_t want,
                               input logic [W-1:0] want_v, input logic [W-1:0] got_v);
        if (want_v !== got_v)
        begin
            errors++;
            $display("%0t: %s mismatch for a=%h b=%h: expected %h actual %h",
                     $time, field, want.a, want.b, want_v, got_v);
        end
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        bezout_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (bezout_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none actual divisor=%h",
                         $time, res_if.divisor);
            end
            else
            begin
                want = bezout_q.pop_front();
                check_field("divisor", want, want.divisor, res_if.divisor);
                check_field("coef_x", want, want.coef_x, res_if.coef_x);
                check_field("coef_y", want, want.coef_y, res_if.coef_y);
                check_field("step_count", want, W'(want.step_count), W'(res_if.step_count));
            end
        end
    end

    // Result sink: random stall per result, plus a long hold when requested
    initial
    begin : result_sink
        int stall;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_len > 0)
            begin
                res_if.ready = 1'b0;
                repeat (hold_len) @(negedge clk);
                hold_len = 0;
            end
            stall = out_idle ? $urandom_range(0, IDLE_MAX) : 0;
            if (stall > 0)
            begin
                res_if.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_if.ready = 1'b1;
            do
                @(posedge clk);
            while (!res_if.valid);
            @(negedge clk);
        end
    end

    // Abort a hung run
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: timeout with %0d results outstanding", $time, bezout_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic test_directed();
        logic [W-1:0] fa, fb;
        in_idle  = 1'b1;
        out_idle = 1'b1;
        // zero operands
        send_pair(32'd0, 32'd0);
        send_pair(32'd0, 32'd5);
        send_pair(-32'sd7, 32'd0);
        send_pair(32'h8000_0000, 32'd0);
        send_pair(32'd0, 32'h8000_0000);
        // most negative and most positive
        send_pair(32'h8000_0000, 32'h8000_0000);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pair(32'h8000_0000, 32'h7FFF_FFFF);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000);
        send_pair(32'h8000_0000, 32'hFFFF_FFFF);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFE);
        send_pair(32'h8000_0000, 32'd6);
        // smaller magnitude divides the larger
        send_pair(32'd12, 32'd4);
        send_pair(-32'sd12, 32'd4);
        send_pair(32'd3, -32'sd21);
        // equal magnitudes
        send_pair(32'd5, -32'sd5);
        send_pair(-32'sd5, 32'd5);
        send_pair(32'd1, 32'd1);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // ordinary and longest remainder chains
        send_pair(32'd240, 32'd46);
        fib_pair(46, fa, fb);
        send_pair(fa, fb);
        send_pair(-fb, fa);
        send_pair(fb, -fa);
        wait_drain();
    endtask

    task automatic test_random();
        logic [W-1:0] a, b, g;
        int           kind;
        for (int i = 0; i < 330; i++)
        begin
            // change idling mode every few dozen requests
            if (i % 40 == 0)
            begin
                in_idle  = $urandom_range(0, 3) != 0;
                out_idle = $urandom_range(0, 3) != 0;
            end
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3:
                begin
                    a = $urandom;
                    b = $urandom;
                end
                4:
                begin
                    fib_pair($urandom_range(2, 46), a, b);
                    a = random_sign(a);
                    b = random_sign(b);
                    if ($urandom_range(0, 1))
                        {a, b} = {b, a};
                end
                5:
                begin
                    g = $urandom_range(1, 5000);
                    a = random_sign(g * $urandom_range(0, 400000));
                    b = random_sign(g * $urandom_range(0, 400000));
                end
                6:
                begin
                    a = random_sign($urandom_range(0, 1000));
                    b = random_sign($urandom_range(0, 1000));
                end
                7:
                begin
                    case ($urandom_range(0, 4))
                        0: a = 32'h8000_0000;
                        1: a = 32'h7FFF_FFFF;
                        2: a = 32'd0;
                        3: a = 32'hFFFF_FFFF;
                        default: a = 32'd1;
                    endcase
                    b = $urandom;
                    if ($urandom_range(0, 1))
                        {a, b} = {b, a};
                end
                8:
                begin
                    b = $urandom_range(1, 1000);
                    a = random_sign(b * $urandom_range(1, 1000));
                    b = random_sign(b);
                end
                default:
                begin
                    a = random_sign($urandom >> $urandom_range(0, 31));
                    b = random_sign($urandom >> $urandom_range(0, 31));
                end
            endcase
            send_pair(a, b);
        end
        wait_drain();
    endtask

    task automatic test_backpressure();
        in_idle  = 1'b0;
        out_idle = 1'b0;
        // hold the sink after the next result while requests keep coming
        hold_len = 2500;
        send_pair(32'd91, 32'd35);
        for (int i = 0; i < 12; i++)
            send_pair(random_sign($urandom_range(1, 300)), random_sign($urandom_range(1, 300)));
        wait_drain();
    endtask

    initial
    begin
        errors          = 0;
        in_idle         = 1'b0;
        out_idle        = 1'b0;
        hold_len        = 0;
        rst_n           = 1'b0;
        op_if.valid     = 1'b0;
        op_if.operand_a = '0;
        op_if.operand_b = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_backpressure();
        test_random();

        // let any stray result show up
        repeat (100) @(negedge clk);
        if (bezout_q.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results never arrived", $time, bezout_q.size());
        end
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
